>>> hdl/lfbe_pkg.sv
// ----------------------------------------------------------------------------
// lfbe_pkg
// shared widths, types and the brightness table of the led fade engine
// ----------------------------------------------------------------------------
package lfbe_pkg;

  // payload field widths
  localparam int CH_FIELD_W = 3;
  localparam int LEVEL_W    = 7;
  localparam int START_W    = 22;
  localparam int HP_W       = 8;
  localparam int HCC_W      = 11;
  localparam int DUTY_W     = 15;

  // per channel counters
  localparam int DELAY_W  = 25;
  localparam int CHANGE_W = 22;
  localparam logic [DELAY_W-1:0]  DELAY_MAX  = '1;
  localparam logic [CHANGE_W-1:0] CHANGE_MAX = '1;

  localparam int LEVEL_COUNT = 100;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL = 7'd99;

  // parameter defaults
  localparam int CHANNELS_DEF  = 8;
  localparam int TPS_DEF       = 10;
  localparam int FRAC_BITS_DEF = 16;

  // fixed width part of one channel record
  typedef struct packed {
    logic [LEVEL_W-1:0]  cur_level;
    logic [LEVEL_W-1:0]  span_high;
    logic [LEVEL_W-1:0]  span_low;
    logic [DELAY_W-1:0]  delay;
    logic [CHANGE_W-1:0] change;
  } rec_fix_t;

  // what the update unit does to the record passing by
  typedef struct packed {
    logic tick;
    logic apply;
  } ctl_t;

  // prepared schedule values
  typedef struct packed {
    logic [LEVEL_W-1:0]  hi;
    logic [LEVEL_W-1:0]  lo;
    logic [DELAY_W-1:0]  delay;
    logic [CHANGE_W-1:0] change;
    logic                neg;
  } sched_t;

  typedef logic [LEVEL_COUNT-1:0][DUTY_W-1:0] duty_rom_t;

  // 0.11 * 1.07^level * 256, rounded, built with 40 fraction bits
  function automatic duty_rom_t build_duty_rom();
    duty_rom_t   rom;
    logic [63:0] x;
    x = ((64'd2816 << 40) + 64'd50) / 64'd100;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      rom[i] = DUTY_W'((x + (64'd1 << 39)) >> 40);
      x = (x * 64'd107 + 64'd50) / 64'd100;
    end
    return rom;
  endfunction

  localparam duty_rom_t DUTY_ROM = build_duty_rom();

endpackage

>>> hdl/lfbe_in_if.sv
// ----------------------------------------------------------------------------
// lfbe_in_if
// request channel: ticks and schedule items
// ----------------------------------------------------------------------------
interface lfbe_in_if import lfbe_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [CH_FIELD_W-1:0] channel;
  logic [LEVEL_W-1:0]    target_level;
  logic [START_W-1:0]    start_delay_s;
  logic [HP_W-1:0]       half_period_s;
  logic [HCC_W-1:0]      half_cycle_count;

  modport source (
    output valid, func, channel, target_level, start_delay_s, half_period_s,
           half_cycle_count,
    input  ready
  );
  modport sink (
    input  valid, func, channel, target_level, start_delay_s, half_period_s,
           half_cycle_count,
    output ready
  );
endinterface

>>> hdl/lfbe_out_if.sv
// ----------------------------------------------------------------------------
// lfbe_out_if
// result channel: one level and duty report per channel
// ----------------------------------------------------------------------------
interface lfbe_out_if import lfbe_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CH_FIELD_W-1:0] out_channel;
  logic [LEVEL_W-1:0]    level;
  logic [DUTY_W-1:0]     duty;
  logic                  updated;
  logic                  last;

  modport source (output valid, out_channel, level, duty, updated, last, input ready);
  modport sink   (input valid, out_channel, level, duty, updated, last, output ready);
endinterface

>>> hdl/lfbe_div.sv
// ----------------------------------------------------------------------------
// lfbe_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lfbe_div import lfbe_pkg::*; #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem, acc[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = !diff[DEN_W];
  assign quo    = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      acc <= {acc[NUM_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

endmodule

>>> hdl/lfbe_cell.sv
// ----------------------------------------------------------------------------
// lfbe_cell
// one channel record in the rotating ring
// ----------------------------------------------------------------------------
module lfbe_cell import lfbe_pkg::*; #(
  parameter  int FRAC_BITS = FRAC_BITS_DEF,
  localparam int STEP_W    = FRAC_BITS + 9,
  localparam int RAMP_W    = FRAC_BITS + 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     shift,
  input  rec_fix_t                 fix_in,
  input  logic signed [STEP_W-1:0] step_in,
  input  logic signed [RAMP_W-1:0] ramp_in,
  output rec_fix_t                 fix_q,
  output logic signed [STEP_W-1:0] step_q,
  output logic signed [RAMP_W-1:0] ramp_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      fix_q  <= '0;
      step_q <= '0;
      ramp_q <= '0;
    end else if (shift) begin
      fix_q  <= fix_in;
      step_q <= step_in;
      ramp_q <= ramp_in;
    end
  end

endmodule

>>> hdl/lfbe_proc.sv
// ----------------------------------------------------------------------------
// lfbe_proc
// update of the record leaving the head of the ring: tick step or schedule load
// ----------------------------------------------------------------------------
module lfbe_proc import lfbe_pkg::*; #(
  parameter  int FRAC_BITS = FRAC_BITS_DEF,
  localparam int STEP_W    = FRAC_BITS + 9,
  localparam int RAMP_W    = FRAC_BITS + 10,
  localparam int QUO_W     = LEVEL_W + FRAC_BITS
) (
  input  ctl_t                     ctl,
  input  sched_t                   sched,
  input  logic [QUO_W-1:0]         quo,
  input  rec_fix_t                 fix_in,
  input  logic signed [STEP_W-1:0] step_in,
  input  logic signed [RAMP_W-1:0] ramp_in,
  output rec_fix_t                 fix_out,
  output logic signed [STEP_W-1:0] step_out,
  output logic signed [RAMP_W-1:0] ramp_out,
  output logic                     updated
);
  localparam int Q_W   = RAMP_W - FRAC_BITS;
  localparam int PAD_W = RAMP_W - LEVEL_W - FRAC_BITS;

  logic signed [RAMP_W-1:0] step_ext;
  logic signed [RAMP_W-1:0] ramp_sum;
  logic signed [RAMP_W-1:0] hi_f;
  logic signed [RAMP_W-1:0] lo_f;
  logic [Q_W-1:0]           q;
  logic [STEP_W-1:0]        mag;

  assign step_ext = {{(RAMP_W-STEP_W){step_in[STEP_W-1]}}, step_in};
  assign ramp_sum = ramp_in + step_ext;
  assign hi_f     = {{PAD_W{1'b0}}, fix_in.span_high, {FRAC_BITS{1'b0}}};
  assign lo_f     = {{PAD_W{1'b0}}, fix_in.span_low, {FRAC_BITS{1'b0}}};
  assign q        = ramp_sum[RAMP_W-1:FRAC_BITS];
  assign mag      = {{(STEP_W-QUO_W){1'b0}}, quo};

  always_comb begin
    fix_out  = fix_in;
    step_out = step_in;
    ramp_out = ramp_in;
    updated  = 1'b0;
    priority if (ctl.apply) begin
      fix_out.span_high = sched.hi;
      fix_out.span_low  = sched.lo;
      fix_out.delay     = sched.delay;
      fix_out.change    = sched.change;
      step_out          = sched.neg ? -mag : mag;
      ramp_out          = {{PAD_W{1'b0}}, fix_in.cur_level, {FRAC_BITS{1'b0}}};
    end else if (ctl.tick) begin
      if (fix_in.delay != '0) begin
        fix_out.delay = fix_in.delay - 1'b1;
      end else if (fix_in.change != '0) begin
        ramp_out = ramp_sum;
        // bounce off either end of the span
        if (ramp_sum > hi_f || ramp_sum < lo_f) begin
          step_out = -step_in;
        end
        if (ramp_sum[RAMP_W-1]) begin
          fix_out.cur_level = fix_in.span_low;
        end else if (q > Q_W'(fix_in.span_high)) begin
          fix_out.cur_level = fix_in.span_high;
        end else if (q < Q_W'(fix_in.span_low)) begin
          fix_out.cur_level = fix_in.span_low;
        end else begin
          fix_out.cur_level = q[LEVEL_W-1:0];
        end
        fix_out.change = fix_in.change - 1'b1;
        updated        = 1'b1;
      end
    end else begin
      fix_out = fix_in;
    end
  end

endmodule

>>> hdl/led_fade_breathing_engine.sv
// ----------------------------------------------------------------------------
// led_fade_breathing_engine
// per channel fade and breathing ramps with exponential brightness duty
// ----------------------------------------------------------------------------
// usage
//   req carries one transaction per item: func low is a 100 ms tick, func high
//   schedules a channel (target level, start delay, half period, cycle count)
//   rsp carries CHANNELS transactions per tick, channel 0 first, last set on
//   the final one; a schedule item gives no result
// timing
//   channel records sit in a ring of cells that rotates by one cell per cycle
//   when not stalled; one update unit sits between its head and its tail
//   tick: a full rotation of the ring, one result per cycle while the output
//   register is free; the state register enters the tick pass, then the
//   output register takes the first result. schedule: capture, prep and
//   divider start states, a bit-serial divide, then a full rotation (an equal
//   target ends after prep); ready returns high once the ring is home again
// reset
//   synchronous; every level, span, step, ramp and counter clears to zero
// stall
//   a held result stops the ring in place during a tick pass; rotation resumes
//   in the cycle the output register is taken, so no result is lost or repeated
// ----------------------------------------------------------------------------
module led_fade_breathing_engine import lfbe_pkg::*; #(
  parameter int CHANNELS         = CHANNELS_DEF,
  parameter int TICKS_PER_SECOND = TPS_DEF,
  parameter int FRAC_BITS        = FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  lfbe_in_if.sink  req,
  lfbe_out_if.source rsp
);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
  localparam int STEP_W = FRAC_BITS + 9;
  localparam int RAMP_W = FRAC_BITS + 10;
  localparam int QUO_W  = LEVEL_W + FRAC_BITS;
  localparam int N_W    = HP_W + TPS_W;
  localparam int D_W    = (START_W + TPS_W > DELAY_W) ? START_W + TPS_W : DELAY_W + 1;
  localparam int C_W    = (N_W + HCC_W > CHANGE_W) ? N_W + HCC_W : CHANGE_W + 1;
  localparam logic [CH_W-1:0] LAST = CH_W'(CHANNELS - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_CHG  = 6'b000100,
    S_DIV  = 6'b001000,
    S_ROT  = 6'b010000,
    S_TICK = 6'b100000
  } state_t;

  state_t          state;
  logic [CH_W-1:0] cnt;

  // captured schedule request
  logic [CH_W-1:0]    sch_ch;
  logic [LEVEL_W-1:0] tgt_q;
  logic [START_W-1:0] s_q;
  logic [HP_W-1:0]    hp_q;
  logic [HCC_W-1:0]   hcc_q;

  // prepared schedule values
  sched_t          sched;
  logic [N_W-1:0]  n_q;

  // set-up arithmetic
  logic [LEVEL_W-1:0] from_lvl;
  logic [N_W-1:0]     n_prod;
  logic [D_W-1:0]     d_prod;
  logic [C_W-1:0]     c_prod;

  // ring of channel records
  rec_fix_t                 cell_fix  [CHANNELS];
  logic signed [STEP_W-1:0] cell_step [CHANNELS];
  logic signed [RAMP_W-1:0] cell_ramp [CHANNELS];
  rec_fix_t                 proc_fix;
  logic signed [STEP_W-1:0] proc_step;
  logic signed [RAMP_W-1:0] proc_ramp;
  logic                     proc_upd;
  ctl_t                     ctl;

  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [QUO_W-1:0] div_quo;

  // output register
  logic                  out_vld;
  logic [CH_FIELD_W-1:0] out_ch_q;
  logic [LEVEL_W-1:0]    level_q;
  logic [DUTY_W-1:0]     duty_q;
  logic                  upd_q;
  logic                  last_q;

  logic in_acc;
  logic ch_ok;
  logic tick_go;
  logic rot_go;
  logic shift;
  logic [LEVEL_W-1:0] duty_idx;

  assign req.ready = (state == S_IDLE);
  assign in_acc    = req.valid && req.ready;
  assign ch_ok     = 32'(req.channel) < 32'(CHANNELS);

  // a tick step needs a free output register, a schedule pass never waits
  assign tick_go   = (state == S_TICK) && (!out_vld || rsp.ready);
  assign rot_go    = (state == S_ROT);
  assign shift     = tick_go || rot_go;
  assign ctl.tick  = (state == S_TICK);
  assign ctl.apply = rot_go && (cnt == sch_ch);
  assign div_start = (state == S_CHG);

  // all cells are at home while idle, so the channel's own cell has its level
  assign from_lvl = cell_fix[sch_ch].cur_level;
  assign n_prod   = N_W'(hp_q) * N_W'(TICKS_PER_SECOND);
  assign d_prod   = D_W'(s_q) * D_W'(TICKS_PER_SECOND);
  assign c_prod   = C_W'(n_q) * C_W'(hcc_q);

  // ring: each cell takes its upper neighbor, the tail takes the updated head
  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    rec_fix_t                 fi;
    logic signed [STEP_W-1:0] si;
    logic signed [RAMP_W-1:0] ri;
    if (i == CHANNELS - 1) begin : g_tail
      assign fi = proc_fix;
      assign si = proc_step;
      assign ri = proc_ramp;
    end else begin : g_body
      assign fi = cell_fix[i+1];
      assign si = cell_step[i+1];
      assign ri = cell_ramp[i+1];
    end
    lfbe_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .fix_in  (fi),
      .step_in (si),
      .ramp_in (ri),
      .fix_q   (cell_fix[i]),
      .step_q  (cell_step[i]),
      .ramp_q  (cell_ramp[i])
    );
  end

  lfbe_proc #(.FRAC_BITS(FRAC_BITS)) u_proc (
    .ctl      (ctl),
    .sched    (sched),
    .quo      (div_quo),
    .fix_in   (cell_fix[0]),
    .step_in  (cell_step[0]),
    .ramp_in  (cell_ramp[0]),
    .fix_out  (proc_fix),
    .step_out (proc_step),
    .ramp_out (proc_ramp),
    .updated  (proc_upd)
  );

  // step size: span in fixed point over ticks per half period
  lfbe_div #(.NUM_W(QUO_W), .DEN_W(N_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({sched.hi - sched.lo, {FRAC_BITS{1'b0}}}),
    .den   (n_q),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      out_vld <= 1'b0;
    end else begin
      if (tick_go) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            cnt <= '0;
            if (!req.func) begin
              state <= S_TICK;
            end else if (ch_ok) begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          // equal target leaves the running ramp alone
          state <= (from_lvl == tgt_q) ? S_IDLE : S_CHG;
        end
        S_CHG: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_TICK: begin
          if (tick_go) begin
            if (cnt == LAST) begin
              cnt   <= '0;
              state <= S_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request capture and schedule set-up
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sch_ch <= CH_W'(req.channel);
      tgt_q  <= (req.target_level > MAX_LEVEL) ? MAX_LEVEL : req.target_level;
      s_q    <= req.start_delay_s;
      hp_q   <= req.half_period_s;
      hcc_q  <= req.half_cycle_count;
    end
    if (state == S_PREP) begin
      sched.hi    <= (from_lvl > tgt_q) ? from_lvl : tgt_q;
      sched.lo    <= (from_lvl > tgt_q) ? tgt_q : from_lvl;
      sched.neg   <= (from_lvl > tgt_q);
      n_q         <= (n_prod == '0) ? N_W'(1) : n_prod;
      sched.delay <= (d_prod > D_W'(DELAY_MAX)) ? DELAY_MAX : d_prod[DELAY_W-1:0];
    end
    if (state == S_CHG) begin
      sched.change <= (c_prod > C_W'(CHANGE_MAX)) ? CHANGE_MAX : c_prod[CHANGE_W-1:0];
    end
  end

  // result payload, taken from the record just updated
  assign duty_idx = (proc_fix.cur_level < LEVEL_W'(LEVEL_COUNT)) ? proc_fix.cur_level
                                                                 : MAX_LEVEL;

  always_ff @(posedge clk) begin
    if (tick_go) begin
      out_ch_q <= CH_FIELD_W'(cnt);
      level_q  <= proc_fix.cur_level;
      duty_q   <= DUTY_ROM[duty_idx];
      upd_q    <= proc_upd;
      last_q   <= (cnt == LAST);
    end
  end

  assign rsp.valid       = out_vld;
  assign rsp.out_channel = out_ch_q;
  assign rsp.level       = level_q;
  assign rsp.duty        = duty_q;
  assign rsp.updated     = upd_q;
  assign rsp.last        = last_q;

  // checks
  a_ready_div: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !div_busy)
    else $error("request taken while the divider is busy");

  a_tick_wrap: assert property (@(posedge clk) disable iff (rst)
    (tick_go && cnt == LAST) |=> (state == S_IDLE && out_vld && rsp.last))
    else $error("tick pass did not close on the last channel");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide wait");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK || state == S_ROT) |-> cnt <= LAST)
    else $error("ring position out of range");

endmodule

>>> tb/sv/tb_led_fade_breathing_engine.sv
// ----------------------------------------------------------------------------
// tb_led_fade_breathing_engine
// self-checking bench for the eight channel led fade and breathing engine
// ----------------------------------------------------------------------------
// a queue of request transactions (ticks and channel schedules) feeds a clocked
// driver; a clocked monitor takes the level reports. every accepted request
// runs through a cycle-free model of the channel ramps, and each tick pushes
// the eight reports it should produce. reports are compared field by field in
// arrival order. both sides pause at random between transactions, with bursts
// of back-to-back traffic in between.
// ----------------------------------------------------------------------------
module tb_led_fade_breathing_engine import lfbe_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_CH           = CHANNELS_DEF;
  localparam int TPS            = TPS_DEF;
  localparam int FB             = FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS   = 240;
  localparam int MAX_GAP        = 14;
  localparam int WATCHDOG_LIMIT = 1000;  // idle cycles with no transaction at all
  localparam int TAIL_CYCLES    = 100;   // room for a trailing schedule after the drain

  typedef enum logic {FUNC_TICK = 1'b0, FUNC_SCHED = 1'b1} func_e;

  typedef struct packed {
    func_e                 func;
    logic [CH_FIELD_W-1:0] channel;
    logic [LEVEL_W-1:0]    target_level;
    logic [START_W-1:0]    start_delay_s;
    logic [HP_W-1:0]       half_period_s;
    logic [HCC_W-1:0]      half_cycle_count;
  } fade_req_t;

  typedef struct packed {
    logic [CH_FIELD_W-1:0] out_channel;
    logic [LEVEL_W-1:0]    level;
    logic [DUTY_W-1:0]     duty;
    logic                  updated;
    logic                  last;
  } level_report_t;

  logic clk;
  logic rst;

  lfbe_in_if  req_if ();
  lfbe_out_if rsp_if ();

  led_fade_breathing_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // stimulus and expected reports
  fade_req_t     requests_pending[$];
  level_report_t reports_due[$];
  int            n_errors;
  int            idle_cycles;

  // model state, one entry per channel
  logic [LEVEL_W-1:0]  lvl_m  [N_CH];
  logic [LEVEL_W-1:0]  hi_m   [N_CH];
  logic [LEVEL_W-1:0]  lo_m   [N_CH];
  longint              step_m [N_CH];
  longint              ramp_m [N_CH];
  logic [DELAY_W-1:0]  delay_m[N_CH];
  logic [CHANGE_W-1:0] runs_m [N_CH];
  logic [DUTY_W-1:0]   bright_tab[LEVEL_COUNT];

  // --------------------------------------------------------------------------
  // model of one accepted request
  // --------------------------------------------------------------------------
  task automatic advance_fade(input fade_req_t r);
    int unsigned       c;
    int unsigned       tgt;
    int unsigned       from;
    int unsigned       hi;
    int unsigned       lo;
    longint unsigned   d;
    longint unsigned   n;
    longint unsigned   chg;
    longint            mag;
    longint            hif;
    longint            lof;
    longint            q;
    logic [LEVEL_W-1:0] v;
    logic              upd;
    level_report_t     rep;
    if (r.func == FUNC_SCHED) begin
      c    = r.channel;
      // targets above the top level saturate
      tgt  = (r.target_level > MAX_LEVEL) ? MAX_LEVEL : r.target_level;
      from = lvl_m[c];
      // equal target: the running ramp is left alone
      if (from != tgt) begin
        hi = (from > tgt) ? from : tgt;
        lo = (from > tgt) ? tgt : from;
        hi_m[c] = LEVEL_W'(hi);
        lo_m[c] = LEVEL_W'(lo);
        // start delay in ticks, saturating
        d = longint'(r.start_delay_s) * TPS;
        delay_m[c] = (d > DELAY_MAX) ? DELAY_MAX : DELAY_W'(d);
        // ticks per half period, at least one
        n = longint'(r.half_period_s) * TPS;
        if (n == 0) begin
          n = 1;
        end
        mag = (longint'(hi - lo) <<< FB) / longint'(n);
        step_m[c] = (from > tgt) ? -mag : mag;
        // number of change steps, saturating
        chg = n * longint'(r.half_cycle_count);
        runs_m[c] = (chg > CHANGE_MAX) ? CHANGE_MAX : CHANGE_W'(chg);
        ramp_m[c] = longint'(from) <<< FB;
      end
    end else begin
      for (c = 0; c < N_CH; c++) begin
        upd = 1'b0;
        if (delay_m[c] != 0) begin
          delay_m[c] = delay_m[c] - 1'b1;
        end else if (runs_m[c] != 0) begin
          hif = longint'(hi_m[c]) <<< FB;
          lof = longint'(lo_m[c]) <<< FB;
          ramp_m[c] = ramp_m[c] + step_m[c];
          // past either end: turn around, the ramp itself is not clamped
          if (ramp_m[c] > hif || ramp_m[c] < lof) begin
            step_m[c] = -step_m[c];
          end
          if (ramp_m[c] < 0) begin
            v = lo_m[c];
          end else begin
            q = ramp_m[c] >>> FB;
            if (q > longint'(hi_m[c])) begin
              v = hi_m[c];
            end else if (q < longint'(lo_m[c])) begin
              v = lo_m[c];
            end else begin
              v = LEVEL_W'(q);
            end
          end
          lvl_m[c]  = v;
          runs_m[c] = runs_m[c] - 1'b1;
          upd       = 1'b1;
        end
        rep.out_channel = CH_FIELD_W'(c);
        rep.level       = lvl_m[c];
        rep.duty        = bright_tab[(lvl_m[c] < LEVEL_COUNT) ? lvl_m[c] : MAX_LEVEL];
        rep.updated     = upd;
        rep.last        = (c == N_CH - 1);
        reports_due.push_back(rep);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_tick();
    fade_req_t   r;
    logic [63:0] junk;
    // the other fields carry junk, a tick must ignore them
    junk   = {$urandom, $urandom};
    r      = junk[$bits(fade_req_t)-1:0];
    r.func = FUNC_TICK;
    requests_pending.push_back(r);
  endtask

  task automatic add_sched(input logic [CH_FIELD_W-1:0] ch, input logic [LEVEL_W-1:0] tgt,
                           input logic [START_W-1:0] dly, input logic [HP_W-1:0] hp,
                           input logic [HCC_W-1:0] hcc);
    fade_req_t r;
    r.func             = FUNC_SCHED;
    r.channel          = ch;
    r.target_level     = tgt;
    r.start_delay_s    = dly;
    r.half_period_s    = hp;
    r.half_cycle_count = hcc;
    requests_pending.push_back(r);
  endtask

  // pause before the next transaction; bursts switch idling off for a while
  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 24) == 0) begin
      burst = !burst;
    end
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // request driver: offers the queue head after a random pause
  // --------------------------------------------------------------------------
  fade_req_t req_cur;
  bit        req_active;
  bit        req_burst;
  int        req_gap;

  always @(posedge clk) begin
    if (rst) begin
      req_active = 1'b0;
      req_gap    = 0;
      req_if.valid <= 1'b0;
    end else begin
      // transaction taken at this edge: update the model
      if (req_if.valid && req_if.ready) begin
        advance_fade(req_cur);
        req_active = 1'b0;
        req_gap    = draw_gap(req_burst);
      end
      if (!req_active) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (requests_pending.size() > 0) begin
          req_cur    = requests_pending.pop_front();
          req_active = 1'b1;
          req_if.func             <= req_cur.func;
          req_if.channel          <= req_cur.channel;
          req_if.target_level     <= req_cur.target_level;
          req_if.start_delay_s    <= req_cur.start_delay_s;
          req_if.half_period_s    <= req_cur.half_period_s;
          req_if.half_cycle_count <= req_cur.half_cycle_count;
        end
      end
      // one write of valid per edge, so a held valid never drops
      req_if.valid <= req_active;
    end
  end

  // --------------------------------------------------------------------------
  // report monitor: takes a report, then holds ready low for a random spell
  // --------------------------------------------------------------------------
  bit rsp_open;
  bit rsp_burst;
  int rsp_gap;

  always @(posedge clk) begin
    level_report_t want;
    if (rst) begin
      rsp_open = 1'b0;
      rsp_gap  = 0;
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (reports_due.size() == 0) begin
          $error("unexpected report: out_channel %0d level %0d", rsp_if.out_channel,
                 rsp_if.level);
          n_errors++;
        end else begin
          want = reports_due.pop_front();
          check_field("out_channel", want.out_channel, rsp_if.out_channel);
          check_field("level",       want.level,       rsp_if.level);
          check_field("duty",        want.duty,        rsp_if.duty);
          check_field("updated",     want.updated,     rsp_if.updated);
          check_field("last",        want.last,        rsp_if.last);
        end
        rsp_open = 1'b0;
        rsp_gap  = draw_gap(rsp_burst);
      end
      if (!rsp_open) begin
        if (rsp_gap > 0) begin
          rsp_gap--;
        end else begin
          rsp_open = 1'b1;
        end
      end
      rsp_if.ready <= rsp_open;
    end
  end

  // watchdog: cycles in which neither channel moves a transaction
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // sequence: reset, directed items, random items, drain, verdict
  // --------------------------------------------------------------------------
  initial begin
    logic [63:0] acc;
    bit          timed_out;
    bit          drained;
    int          sel;

    // every input known from time zero
    rst                     = 1'b1;
    req_if.valid            = 1'b0;
    req_if.func             = FUNC_TICK;
    req_if.channel          = '0;
    req_if.target_level     = '0;
    req_if.start_delay_s    = '0;
    req_if.half_period_s    = '0;
    req_if.half_cycle_count = '0;
    rsp_if.ready            = 1'b0;
    n_errors                = 0;
    idle_cycles             = 0;
    req_burst               = 1'b0;
    rsp_burst               = 1'b0;
    timed_out               = 1'b0;
    drained                 = 1'b0;

    // brightness table: 0.11 * 1.07^L * 256 in 40 fraction bits, rounded
    acc = ((64'd2816 << 40) + 64'd50) / 64'd100;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      bright_tab[i] = DUTY_W'((acc + (64'd1 << 39)) >> 40);
      acc = (acc * 64'd107 + 64'd50) / 64'd100;
    end

    for (int c = 0; c < N_CH; c++) begin
      lvl_m[c]   = '0;
      hi_m[c]    = '0;
      lo_m[c]    = '0;
      step_m[c]  = 0;
      ramp_m[c]  = 0;
      delay_m[c] = '0;
      runs_m[c]  = '0;
    end

    // directed part
    add_tick();                                       // all channels at rest
    add_sched(3'd0, 7'd0, 22'd5, 8'd1, 11'd4);        // equal target, no effect
    add_sched(3'd1, 7'd127, 22'd0, 8'd0, 11'd3);      // saturating target, one tick per half
    add_sched(3'd2, 7'd50, 22'd1, 8'd1, 11'd2);       // delayed start, whole-level step
    add_sched(3'd3, 7'd99, 22'h3FFFFF, 8'd255, 11'd2047); // delay and run both saturate
    add_sched(3'd4, 7'd10, 22'd0, 8'd0, 11'd2047);
    add_sched(3'd7, 7'd1, 22'd0, 8'd3, 11'd5);
    repeat (4) add_tick();                            // ch1 overshoots the top and turns
    add_sched(3'd1, 7'd0, 22'd0, 8'd0, 11'd4);        // ramp driven below zero
    add_sched(3'd5, 7'd7, 22'd0, 8'd2, 11'd1);
    add_sched(3'd6, 7'd99, 22'd0, 8'd0, 11'd0);       // no change steps at all
    repeat (5) add_tick();
    add_sched(3'd4, 7'd64, 22'd0, 8'd128, 11'd1024);
    add_sched(3'd2, 7'd0, 22'h200000, 8'd0, 11'd1);
    repeat (3) add_tick();

    // random part: mostly ticks, well-formed short ramps, some raw noise
    repeat (RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 58) begin
        add_tick();
      end else if (sel < 88) begin
        add_sched(CH_FIELD_W'($urandom_range(0, N_CH - 1)), LEVEL_W'($urandom_range(0, 99)),
                  START_W'($urandom_range(0, 1)), HP_W'($urandom_range(0, 3)),
                  HCC_W'($urandom_range(1, 8)));
      end else begin
        add_sched(CH_FIELD_W'($urandom), LEVEL_W'($urandom), START_W'($urandom),
                  HP_W'($urandom), HCC_W'($urandom));
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // wait until everything is sent and every report has come back
    while (!drained && !timed_out) begin
      @(negedge clk);
      timed_out = (idle_cycles >= WATCHDOG_LIMIT);
      drained   = (requests_pending.size() == 0) && !req_active && (reports_due.size() == 0);
    end
    // a trailing schedule may still be in flight; stray reports get caught here
    if (!timed_out) begin
      repeat (TAIL_CYCLES) @(posedge clk);
    end

    if (!timed_out && n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> led_fade_breathing_engine.f
hdl/lfbe_pkg.sv
hdl/lfbe_in_if.sv
hdl/lfbe_out_if.sv
hdl/lfbe_div.sv
hdl/lfbe_cell.sv
hdl/lfbe_proc.sv
hdl/led_fade_breathing_engine.sv
tb/sv/tb_led_fade_breathing_engine.sv
